/* hdl/bsf_pkg.sv */
package bsf_pkg;

    // Image geometry and sample format.
    localparam int MAX_SIDE    = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COORD_BITS  = $clog2(MAX_SIDE);
    localparam int SIDE_BITS   = COORD_BITS + 1;

    // Configuration register map (register index taken from paddr[2]).
    localparam logic REG_SIDE_IN_USE = 1'b0;
    localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(MAX_SIDE);
    localparam logic [SIDE_BITS-1:0] SIDE_MIN   = SIDE_BITS'(2);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COORD_BITS-1:0]  coord_t;
    typedef logic [SIDE_BITS-1:0]   side_t;

    // 3x3 window indexed [row][col]; row 2 is the newest row, col 2 the newest column.
    typedef sample_t [2:0][2:0] window_t;

    // Border handling for one kernel evaluation.
    typedef struct packed {
        logic top_edge;     // center row is row 0, top row replicated
        logic left_edge;    // center column is column 0, left column replicated
        logic bot_clamp;    // center row is the last row
        logic right_clamp;  // center column is the last column
    } tap_sel_t;

endpackage

/* hdl/bsf_ram.sv */
module bsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/bsf_kernel.sv */
module bsf_kernel (
    input  bsf_pkg::window_t  window,
    input  bsf_pkg::tap_sel_t sel,
    output bsf_pkg::sample_t  smoothed
);

    import bsf_pkg::*;

    logic [1:0]         row_idx [3];
    logic [1:0]         col_idx [3];
    sample_t            tap [3][3];
    logic [SAMPLE_BITS+1:0] row_sum [3];
    logic [SAMPLE_BITS+4:0] total;

    // Map the three kernel rows and columns onto window positions, replicating borders.
    always_comb
    begin
        row_idx[0] = (sel.bot_clamp || sel.top_edge) ? 2'd1 : 2'd0;
        row_idx[1] = sel.bot_clamp ? 2'd2 : 2'd1;
        row_idx[2] = 2'd2;
        col_idx[0] = (sel.right_clamp || sel.left_edge) ? 2'd1 : 2'd0;
        col_idx[1] = sel.right_clamp ? 2'd2 : 2'd1;
        col_idx[2] = 2'd2;
    end

    // Weighted sum 1-2-1 along each row, then 1-2-1 across rows.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                tap[i][j] = window[row_idx[i]][col_idx[j]];
            end
            row_sum[i] = (SAMPLE_BITS+2)'(tap[i][0]) + ((SAMPLE_BITS+2)'(tap[i][1]) << 1)
                       + (SAMPLE_BITS+2)'(tap[i][2]);
        end
        total = (SAMPLE_BITS+5)'(row_sum[0]) + ((SAMPLE_BITS+5)'(row_sum[1]) << 1)
              + (SAMPLE_BITS+5)'(row_sum[2]) + (SAMPLE_BITS+5)'(8);
    end

    // Divide by 16, rounding half up.
    assign smoothed = total[SAMPLE_BITS+3:4];

endmodule

/* hdl/binomial_3x3_smoothing_filter_unit.sv */
// Channel   | Direction | Word contents (lowest bit first)
// ----------+-----------+--------------------------------------------------------
// s_axis    | in        | tdata: sample[15:0]
// m_axis    | out       | tdata: smoothed[15:0], out_col[25:16], out_row[35:26], zero
//           |           | tlast: end_of_run, tuser: end_of_frame
// apb       | in/out    | register 0 at byte address 0: side_in_use[10:0]
//
// One input word per cycle is accepted while s_tready is high; an input passes the stage 1,
// window and stage 2, and output registers on its way to a result. Inputs in the last column
// or last row cause two results, the bottom right input four; the single kernel unit emits
// one result per cycle while m_tready allows, so those inputs hold s_tready low meanwhile.
// Reset clears control state and the window; the line store is not cleared and
// needs no clearing pass. A stalled m_tready backs up through the pipeline.
module binomial_3x3_smoothing_filter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // smoothed[15:0], out_col[25:16], out_row[35:26]
    output logic        m_tlast,
    output logic        m_tuser    // end_of_frame[0]
);

    import bsf_pkg::*;

    side_t    side_reg;
    side_t    side_eff;
    coord_t   last_idx;
    logic     cfg_write;

    coord_t   col_reg, row_reg;
    coord_t   col_cur, row_cur;
    logic     last_col_cur, last_row_cur;
    logic     in_accept;

    logic     s1_valid_reg;
    sample_t  s1_x_reg;
    coord_t   s1_col_reg, s1_row_reg;
    logic     s1_lastc_reg, s1_lastr_reg;
    logic     s1_adv;
    logic     s1_emits;
    logic [2*SAMPLE_BITS-1:0] line_rdata;

    window_t  window_reg, window_next;

    logic     s2_valid_reg;
    coord_t   s2_col_reg, s2_row_reg;
    logic     s2_lastc_reg, s2_lastr_reg;
    logic [1:0] s2_k_reg;
    logic [1:0] s2_final_k;
    logic     s2_done;
    tap_sel_t tap_sel;
    sample_t  kernel_out;
    coord_t   res_col, res_row;
    logic     res_last, res_eof;

    logic     out_valid_reg;
    logic     out_load;
    sample_t  out_smoothed_reg;
    coord_t   out_col_reg, out_row_reg;
    logic     out_last_reg, out_eof_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SIDE_IN_USE);
    assign prdata    = (paddr[2] == REG_SIDE_IN_USE) ? {{(32-SIDE_BITS){1'b0}}, side_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
        end
        else if (cfg_write)
        begin
            side_reg <= pwdata[SIDE_BITS-1:0];
        end
    end

    // Effective side, clamped to the supported range.
    always_comb
    begin
        if (side_reg < SIDE_MIN)
        begin
            side_eff = SIDE_MIN;
        end
        else if (side_reg > SIDE_RESET)
        begin
            side_eff = SIDE_RESET;
        end
        else
        begin
            side_eff = side_reg;
        end
    end
    assign last_idx = COORD_BITS'(side_eff - SIDE_BITS'(1));

    // Raster position of the incoming word.
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        if ((SIDE_BITS'(col_reg) >= side_eff) || (SIDE_BITS'(row_reg) >= side_eff))
        begin
            col_cur = '0;
            row_cur = '0;
        end
        else
        begin
            col_cur = col_reg;
            row_cur = row_reg;
        end
        last_col_cur = (col_cur == last_idx);
        last_row_cur = (row_cur == last_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_write)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            if (last_col_cur)
            begin
                col_reg <= '0;
                row_reg <= last_row_cur ? '0 : row_cur + COORD_BITS'(1);
            end
            else
            begin
                col_reg <= col_cur + COORD_BITS'(1);
                row_reg <= row_cur;
            end
        end
    end

    // Line store: each entry holds {two rows above, one row above} for its column.
    bsf_ram #(
        .WIDTH (2*SAMPLE_BITS),
        .DEPTH (MAX_SIDE)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata ({line_rdata[SAMPLE_BITS-1:0], s1_x_reg}),
        .re    (in_accept),
        .raddr (col_cur),
        .rdata (line_rdata)
    );

    // Stage 1 holds the word while its line entry is read.
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_done);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s1_emits = (s1_col_reg != '0) && (s1_row_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg     <= s_tdata;
            s1_col_reg   <= col_cur;
            s1_row_reg   <= row_cur;
            s1_lastc_reg <= last_col_cur;
            s1_lastr_reg <= last_row_cur;
        end
    end

    // Window shifts left and takes the new column when stage 1 moves on.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            window_next[k][0] = window_reg[k][1];
            window_next[k][1] = window_reg[k][2];
        end
        window_next[0][2] = line_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        window_next[1][2] = line_rdata[SAMPLE_BITS-1:0];
        window_next[2][2] = s1_x_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (s1_adv)
        begin
            window_reg <= window_next;
        end
    end

    // Stage 2 walks through the one to four results of the word, one per cycle while the output register can take them.
    assign s2_final_k = {s2_lastc_reg && s2_lastr_reg, s2_lastc_reg || s2_lastr_reg};
    assign out_load   = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s2_done    = out_load && (s2_k_reg == s2_final_k);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_k_reg     <= '0;
        end
        else if (s1_adv && s1_emits)
        begin
            s2_valid_reg <= 1'b1;
            s2_k_reg     <= '0;
        end
        else if (s2_done)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            s2_k_reg <= s2_k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emits)
        begin
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_lastc_reg <= s1_lastc_reg;
            s2_lastr_reg <= s1_lastr_reg;
        end
    end

    // Border selection and position of the current result.
    always_comb
    begin
        tap_sel.top_edge    = (s2_row_reg < COORD_BITS'(2));
        tap_sel.left_edge   = (s2_col_reg < COORD_BITS'(2));
        tap_sel.right_clamp = s2_lastc_reg && s2_k_reg[0];
        tap_sel.bot_clamp   = s2_lastr_reg && (s2_lastc_reg ? s2_k_reg[1] : s2_k_reg[0]);
        res_col  = s2_col_reg - COORD_BITS'(1) + COORD_BITS'(tap_sel.right_clamp);
        res_row  = s2_row_reg - COORD_BITS'(1) + COORD_BITS'(tap_sel.bot_clamp);
        res_last = (s2_k_reg == s2_final_k);
        res_eof  = res_last && s2_lastc_reg && s2_lastr_reg;
    end

    bsf_kernel u_kernel (
        .window   (window_reg),
        .sel      (tap_sel),
        .smoothed (kernel_out)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_smoothed_reg <= kernel_out;
            out_col_reg      <= res_col;
            out_row_reg      <= res_row;
            out_last_reg     <= res_last;
            out_eof_reg      <= res_eof;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_row_reg, out_col_reg, out_smoothed_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_eof_reg;

endmodule
